@@ rtl/core/rlpp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpp_pkg
// Shared types and constants for the rectangle layer pixel painter.
// ----------------------------------------------------------------------------
package rlpp_pkg;

  localparam int MaxRects = 16;
  localparam int MaxDim   = 512;
  localparam int IdxW     = $clog2(MaxRects);
  localparam int CntW     = $clog2(MaxRects + 1);
  localparam int EntryW   = 20 * 4 + 9;
  localparam int QDepth   = 2;

  localparam logic [1:0] ReqAdd    = 2'd0;
  localparam logic [1:0] ReqQuery  = 2'd1;
  localparam logic [1:0] ReqClear  = 2'd2;
  localparam logic [1:0] ReqUnused = 2'd3;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StIgnored = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;
  localparam logic [1:0] StOutside = 2'd3;

  localparam logic [1:0] RegCanvasWidth  = 2'd0;
  localparam logic [1:0] RegCanvasHeight = 2'd1;
  localparam logic [1:0] RegBackground   = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic               rect_filled;
    logic               rect_known_type;
    logic signed [19:0] rect_left;
    logic signed [19:0] rect_top;
    logic signed [19:0] rect_width;
    logic signed [19:0] rect_height;
    logic [7:0]         rect_char;
    logic [8:0]         pixel_x;
    logic [8:0]         pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_char;
    logic [1:0] status;
  } out_item_t;

  // classified command passed from front to back
  typedef enum logic [1:0] {
    CMD_RESULT,
    CMD_ADD,
    CMD_QUERY,
    CMD_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [1:0] status;
    logic [8:0] pixel_x;
    logic [8:0] pixel_y;
    logic [EntryW-1:0] entry;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DRAIN,
    BK_OUT
  } back_state_t;

endpackage

@@ rtl/core/rect_layer_pixel_painter_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_layer_pixel_painter_unit
// Rectangle table with pixel queries; front checks, back executes.
// ----------------------------------------------------------------------------
// Add, clear and refused requests go from idle straight to the result state;
// a query scans the table RAM, one read per cycle, then drains the last read.
// The back end takes one request at a time; a two-entry queue lets the
// input side take requests while a result waits. Synchronous reset empties
// the table and restores the canvas registers to 300 x 300, background 32.
module rect_layer_pixel_painter_unit (
  input  logic                clk,
  input  logic                rst,
  input  rlpp_pkg::in_item_t  in_data,
  input  logic                in_valid,
  output logic                in_ready,
  output rlpp_pkg::out_item_t out_data,
  output logic                out_valid,
  input  logic                out_ready,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import rlpp_pkg::*;

  logic [9:0] canvas_width, canvas_height;
  logic [7:0] background_char;
  cmd_t       q_data;
  logic       q_valid, q_pop;
  logic [CntW-1:0] count;
  logic       wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width    <= 10'd300;
      canvas_height   <= 10'd300;
      background_char <= 8'd32;
    end else if (wr && paddr[1:0] == 2'b00) begin
      unique case (paddr[3:2])
        RegCanvasWidth:  canvas_width    <= pwdata[9:0];
        RegCanvasHeight: canvas_height   <= pwdata[9:0];
        RegBackground:   background_char <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      RegCanvasWidth:  prdata = {22'd0, canvas_width};
      RegCanvasHeight: prdata = {22'd0, canvas_height};
      RegBackground:   prdata = {24'd0, background_char};
      default:         prdata = '0;
    endcase
  end

  rlpp_front u_front (
    .clk(clk), .rst(rst), .in_data(in_data), .in_valid(in_valid),
    .in_ready(in_ready), .canvas_width(canvas_width),
    .canvas_height(canvas_height), .q_data(q_data), .q_valid(q_valid),
    .q_pop(q_pop)
  );

  rlpp_back u_back (
    .clk(clk), .rst(rst), .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop),
    .background_char(background_char), .out_data(out_data),
    .out_valid(out_valid), .out_ready(out_ready), .count(count)
  );

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(MaxRects)) else $error("rectangle count overflow");
  a_pop_needs_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("queue popped while empty");
  a_outside_no_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != StOk |-> out_data.pixel_char == 8'd0)
    else $error("character on non-ok result");
`endif

endmodule

@@ rtl/core/rlpp_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rlpp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/rlpp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpp_front
// Accepts requests, checks them and pushes classified commands to a queue.
// ----------------------------------------------------------------------------
module rlpp_front (
  input  logic                clk,
  input  logic                rst,
  input  rlpp_pkg::in_item_t  in_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [9:0]          canvas_width,
  input  logic [9:0]          canvas_height,
  output rlpp_pkg::cmd_t      q_data,
  output logic                q_valid,
  input  logic                q_pop
);
  import rlpp_pkg::*;

  cmd_t              q_mem [QDepth];
  logic [$clog2(QDepth)-1:0] wr_ptr, rd_ptr;
  logic [$clog2(QDepth):0]   fill;
  logic              push;
  cmd_t              cmd;
  logic [9:0]        cw, ch;

  assign in_ready = (fill != ($clog2(QDepth)+1)'(QDepth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != '0);
  assign q_data   = q_mem[rd_ptr];

  always_comb begin
    cw = (canvas_width > 10'(MaxDim)) ? 10'(MaxDim) : canvas_width;
    ch = (canvas_height > 10'(MaxDim)) ? 10'(MaxDim) : canvas_height;
    cmd.kind    = CMD_RESULT;
    cmd.status  = StOk;
    cmd.pixel_x = in_data.pixel_x;
    cmd.pixel_y = in_data.pixel_y;
    cmd.entry   = {in_data.rect_left, in_data.rect_top, in_data.rect_width,
                   in_data.rect_height, in_data.rect_filled, in_data.rect_char};
    unique case (in_data.req_type)
      ReqAdd: begin
        if (!in_data.rect_known_type || in_data.rect_width <= 0 ||
            in_data.rect_height <= 0) begin
          cmd.status = StIgnored;
        end else begin
          cmd.kind = CMD_ADD;
        end
      end
      ReqQuery: begin
        if ({1'b0, in_data.pixel_x} >= cw || {1'b0, in_data.pixel_y} >= ch) begin
          cmd.status = StOutside;
        end else begin
          cmd.kind = CMD_QUERY;
        end
      end
      ReqClear: cmd.kind = CMD_CLEAR;
      default:  cmd.kind = CMD_RESULT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cmd;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (push ? 1'b1 : 1'b0) - (q_pop ? 1'b1 : 1'b0);
    end
  end

endmodule

@@ rtl/core/rlpp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpp_back
// Executes commands: stores or clears rectangles and scans the table for queries.
// ----------------------------------------------------------------------------
module rlpp_back (
  input  logic                clk,
  input  logic                rst,
  input  rlpp_pkg::cmd_t      q_data,
  input  logic                q_valid,
  output logic                q_pop,
  input  logic [7:0]          background_char,
  output rlpp_pkg::out_item_t out_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [rlpp_pkg::CntW-1:0] count
);
  import rlpp_pkg::*;

  back_state_t state, state_next;
  logic [CntW-1:0] rect_count, rect_count_next;
  logic [CntW-1:0] scan, scan_next;
  logic            hit_valid, hit_valid_next;
  logic [8:0]      qx, qy;
  logic [7:0]      acc, acc_next;
  out_item_t       res, res_next;
  logic            we;
  logic [EntryW-1:0] rdata;
  logic [IdxW-1:0] raddr;
  logic            cmd_take;

  logic signed [20:0] left, top, right, bottom, px, py;
  logic            in_box, edge_hit, covers;

  assign count = rect_count;

  rlpp_ram #(.Width(EntryW), .Depth(MaxRects)) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(rect_count[IdxW-1:0]),
    .wdata(q_data.entry),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    left   = 21'(signed'(rdata[88:69]));
    top    = 21'(signed'(rdata[68:49]));
    right  = left + 21'(signed'(rdata[48:29]));
    bottom = top + 21'(signed'(rdata[28:9]));
    px     = signed'({4'b0, qx, 8'b0});
    py     = signed'({4'b0, qy, 8'b0});
    in_box = (px >= left) && (px <= right) && (py >= top) && (py <= bottom);
    edge_hit = (px - left < 21'sd256) || (right - px < 21'sd256) ||
               (py - top < 21'sd256) || (bottom - py < 21'sd256);
    covers = in_box && (rdata[8] || edge_hit);
  end

  assign out_valid = (state == BK_OUT);
  assign out_data  = res;

  always_comb begin
    state_next      = state;
    rect_count_next = rect_count;
    scan_next       = scan;
    hit_valid_next  = 1'b0;
    acc_next        = acc;
    res_next        = res;
    we              = 1'b0;
    cmd_take        = 1'b0;
    raddr           = scan[IdxW-1:0];
    if (hit_valid && covers) acc_next = rdata[7:0];
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          cmd_take = 1'b1;
          res_next = '{pixel_char: 8'd0, status: q_data.status};
          unique case (q_data.kind)
            CMD_ADD: begin
              if (rect_count == CntW'(MaxRects)) begin
                res_next.status = StFull;
              end else begin
                we = 1'b1;
                rect_count_next = rect_count + 1'b1;
              end
              state_next = BK_OUT;
            end
            CMD_CLEAR: begin
              rect_count_next = '0;
              state_next = BK_OUT;
            end
            CMD_QUERY: begin
              acc_next   = background_char;
              scan_next  = '0;
              state_next = BK_SCAN;
            end
            default: state_next = BK_OUT;
          endcase
        end
      end
      BK_SCAN: begin
        // issue one table read a cycle; test the previous read
        if (scan == rect_count) begin
          state_next = BK_DRAIN;
        end else begin
          hit_valid_next = 1'b1;
          scan_next = scan + 1'b1;
        end
      end
      BK_DRAIN: begin
        res_next   = '{pixel_char: acc_next, status: StOk};
        state_next = BK_OUT;
      end
      BK_OUT: begin
        if (out_ready) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  assign q_pop = cmd_take;

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      qx <= q_data.pixel_x;
      qy <= q_data.pixel_y;
    end
    acc <= acc_next;
    res <= res_next;
    if (rst) begin
      state      <= BK_IDLE;
      rect_count <= '0;
      scan       <= '0;
      hit_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      rect_count <= rect_count_next;
      scan       <= scan_next;
      hit_valid  <= hit_valid_next;
    end
  end

endmodule
